// File: src/tts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg: shared codes for the time-triggered task scheduler
// Operation, status and sequencer state encodings used across the block.
// ----------------------------------------------------------------------------
package tts_pkg;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_DISPATCH = 3'd1,
        OP_ADD      = 3'd2,
        OP_DELETE   = 3'd3,
        OP_CLEAR    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_WALK   = 2'd1,
        S_FINISH = 2'd2
    } state_t;

    // Most results one dispatch may give.
    localparam int unsigned MAX_RESULTS = 8;
    localparam int unsigned RUNS_MAX    = 255;

endpackage

`default_nettype wire

// File: src/tts_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tts_cell: one task slot in the rotating slot chain
// Holds a full slot entry and loads its neighbor's entry when the chain shifts.
// ----------------------------------------------------------------------------
module tts_cell #(
    parameter int TIME_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   shift_en,
    input  wire logic                   d_valid,
    input  wire logic [7:0]             d_task,
    input  wire logic [TIME_BITS:0]     d_delay,
    input  wire logic [TIME_BITS-1:0]   d_period,
    input  wire logic [7:0]             d_runs,
    output logic                        q_valid,
    output logic [7:0]                  q_task,
    output logic [TIME_BITS:0]          q_delay,
    output logic [TIME_BITS-1:0]        q_period,
    output logic [7:0]                  q_runs
);

    logic                 valid_reg;
    logic [7:0]           task_reg;
    logic [TIME_BITS:0]   delay_reg;
    logic [TIME_BITS-1:0] period_reg;
    logic [7:0]           runs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            task_reg   <= '0;
            delay_reg  <= '0;
            period_reg <= '0;
            runs_reg   <= '0;
        end
        else if (shift_en)
        begin
            valid_reg  <= d_valid;
            task_reg   <= d_task;
            delay_reg  <= d_delay;
            period_reg <= d_period;
            runs_reg   <= d_runs;
        end
    end

    assign q_valid  = valid_reg;
    assign q_task   = task_reg;
    assign q_delay  = delay_reg;
    assign q_period = period_reg;
    assign q_runs   = runs_reg;

endmodule

`default_nettype wire

// File: src/time_triggered_task_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// time_triggered_task_scheduler: cooperative time-triggered task table
// Slots rotate through a chain of cells past one update point at the head.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  input   | in_valid / in_stall | op, task_id, first_delay, repeat_period,
//          |                     | slot_index
//  output  | out_valid/out_stall | slot, run_task_id, status, sticky_error, last
//
//  Per accepted item the slot ring shifts once per cycle unless held, so each
//  slot passes the update point once, and the S_FINISH state ends the item.
//  Reset empties all slots and the error flag; no clearing pass is needed.
//  In a dispatch, a stalled output holds the ring still until the result can be stored.
//  The next item is taken only once the walk is done.
// ----------------------------------------------------------------------------
module time_triggered_task_scheduler #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  op,
    input  wire logic [7:0]  task_id,
    input  wire logic [15:0] first_delay,
    input  wire logic [15:0] repeat_period,
    input  wire logic [2:0]  slot_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       slot,
    output logic [7:0]       run_task_id,
    output logic [1:0]       status,
    output logic             sticky_error,
    output logic             last
);
    import tts_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W = (IDX_W > 3) ? IDX_W : 3;

    logic                 c_valid  [SLOTS];
    logic [7:0]           c_task   [SLOTS];
    logic [TIME_BITS:0]   c_delay  [SLOTS];
    logic [TIME_BITS-1:0] c_period [SLOTS];
    logic [7:0]           c_runs   [SLOTS];

    logic                 n_valid;
    logic [7:0]           n_task;
    logic [TIME_BITS:0]   n_delay;
    logic [TIME_BITS-1:0] n_period;
    logic [7:0]           n_runs;
    logic                 shift_en;

    genvar k;
    generate
        for (k = 0; k < SLOTS; k++)
        begin : g_cell
            if (k == SLOTS - 1)
            begin : g_tail
                tts_cell #(.TIME_BITS(TIME_BITS)) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift_en(shift_en),
                    .d_valid(n_valid), .d_task(n_task), .d_delay(n_delay),
                    .d_period(n_period), .d_runs(n_runs),
                    .q_valid(c_valid[k]), .q_task(c_task[k]), .q_delay(c_delay[k]),
                    .q_period(c_period[k]), .q_runs(c_runs[k])
                );
            end
            else
            begin : g_body
                tts_cell #(.TIME_BITS(TIME_BITS)) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift_en(shift_en),
                    .d_valid(c_valid[k+1]), .d_task(c_task[k+1]),
                    .d_delay(c_delay[k+1]), .d_period(c_period[k+1]),
                    .d_runs(c_runs[k+1]),
                    .q_valid(c_valid[k]), .q_task(c_task[k]), .q_delay(c_delay[k]),
                    .q_period(c_period[k]), .q_runs(c_runs[k])
                );
            end
        end
    endgenerate

    state_t      state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    logic [7:0]  task_reg, task_next;
    logic [15:0] fdel_reg, fdel_next;
    logic [15:0] per_reg, per_next;
    logic [2:0]  idx_reg, idx_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic        found_reg, found_next;
    logic [IDX_W-1:0] rslot_reg, rslot_next;
    logic        delok_reg, delok_next;
    logic        hold_valid_reg, hold_valid_next;
    logic [IDX_W-1:0] hold_slot_reg, hold_slot_next;
    logic [7:0]  hold_tid_reg, hold_tid_next;
    logic [3:0]  disp_reg, disp_next;
    logic        err_reg, err_next;

    logic        ov_reg, ov_next;
    logic [3:0]  oslot_reg, oslot_next;
    logic [7:0]  otid_reg, otid_next;
    logic [1:0]  ostat_reg, ostat_next;
    logic        oerr_reg, oerr_next;
    logic        olast_reg, olast_next;

    logic             can_push;
    logic [TIME_BITS:0] dec;

    assign can_push = !ov_reg || !out_stall;
    assign dec = c_delay[0][TIME_BITS] ? c_delay[0] : c_delay[0] - (TIME_BITS+1)'(1);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        task_next       = task_reg;
        fdel_next       = fdel_reg;
        per_next        = per_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        rslot_next      = rslot_reg;
        delok_next      = delok_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        hold_tid_next   = hold_tid_reg;
        disp_next       = disp_reg;
        err_next        = err_reg;
        ov_next         = ov_reg && out_stall;
        oslot_next      = oslot_reg;
        otid_next       = otid_reg;
        ostat_next      = ostat_reg;
        oerr_next       = oerr_reg;
        olast_next      = olast_reg;
        n_valid         = c_valid[0];
        n_task          = c_task[0];
        n_delay         = c_delay[0];
        n_period        = c_period[0];
        n_runs          = c_runs[0];
        shift_en        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = op;
                    task_next       = task_id;
                    fdel_next       = first_delay;
                    per_next        = repeat_period;
                    idx_next        = slot_index;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    delok_next      = 1'b0;
                    hold_valid_next = 1'b0;
                    disp_next       = '0;
                    state_next      = S_WALK;
                end
            end
            S_WALK:
            begin
                shift_en = 1'b1;
                case (op_reg)
                    OP_TICK:
                    begin
                        if (c_valid[0])
                        begin
                            n_delay = dec;
                            if (dec[TIME_BITS] || dec == '0)
                            begin
                                if (c_runs[0] != 8'(RUNS_MAX))
                                    n_runs = c_runs[0] + 8'd1;
                                if (c_period[0] != '0)
                                    n_delay = {1'b0, c_period[0]};
                            end
                        end
                    end
                    OP_DISPATCH:
                    begin
                        if (c_runs[0] != '0 && disp_reg < 4'(MAX_RESULTS))
                        begin
                            // The previous hit goes out now; this one waits, since
                            // only the walk's end tells which result is last.
                            if (hold_valid_reg && !can_push)
                                shift_en = 1'b0;
                            else
                            begin
                                if (hold_valid_reg)
                                begin
                                    ov_next    = 1'b1;
                                    oslot_next = 4'(hold_slot_reg);
                                    otid_next  = hold_tid_reg;
                                    ostat_next = ST_OK;
                                    oerr_next  = err_reg;
                                    olast_next = 1'b0;
                                end
                                hold_valid_next = 1'b1;
                                hold_slot_next  = cnt_reg;
                                hold_tid_next   = c_task[0];
                                disp_next       = disp_reg + 4'd1;
                                n_runs          = c_runs[0] - 8'd1;
                                if (c_period[0] == '0)
                                begin
                                    n_valid  = 1'b0;
                                    n_task   = '0;
                                    n_delay  = '0;
                                    n_period = '0;
                                    n_runs   = '0;
                                end
                            end
                        end
                    end
                    OP_ADD:
                    begin
                        if (!c_valid[0] && !found_reg)
                        begin
                            found_next = 1'b1;
                            rslot_next = cnt_reg;
                            n_valid    = 1'b1;
                            n_task     = task_reg;
                            n_delay    = {1'b0, TIME_BITS'(fdel_reg)};
                            n_period   = TIME_BITS'(per_reg);
                            n_runs     = '0;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (CMP_W'(cnt_reg) == CMP_W'(idx_reg))
                        begin
                            delok_next = c_valid[0];
                            n_valid    = 1'b0;
                            n_task     = '0;
                            n_delay    = '0;
                            n_period   = '0;
                            n_runs     = '0;
                        end
                    end
                    OP_CLEAR:
                    begin
                        n_valid  = 1'b0;
                        n_task   = '0;
                        n_delay  = '0;
                        n_period = '0;
                        n_runs   = '0;
                    end
                    default:
                    begin
                    end
                endcase
                if (shift_en)
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                    if (cnt_reg == IDX_W'(SLOTS - 1))
                        state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (can_push)
                begin
                    state_next = S_IDLE;
                    otid_next  = '0;
                    ostat_next = ST_OK;
                    olast_next = 1'b1;
                    case (op_reg)
                        OP_DISPATCH:
                        begin
                            if (hold_valid_reg)
                            begin
                                ov_next    = 1'b1;
                                oslot_next = 4'(hold_slot_reg);
                                otid_next  = hold_tid_reg;
                                oerr_next  = err_reg;
                            end
                        end
                        OP_ADD:
                        begin
                            ov_next = 1'b1;
                            if (found_reg)
                            begin
                                oslot_next = 4'(rslot_reg);
                                oerr_next  = err_reg;
                            end
                            else
                            begin
                                oslot_next = 4'(SLOTS);
                                ostat_next = ST_FULL;
                                err_next   = 1'b1;
                                oerr_next  = 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            ov_next    = 1'b1;
                            oslot_next = 4'(idx_reg);
                            if (delok_reg)
                                oerr_next = err_reg;
                            else
                            begin
                                ostat_next = ST_EMPTY;
                                err_next   = 1'b1;
                                oerr_next  = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            ov_next    = 1'b1;
                            oslot_next = '0;
                            err_next   = 1'b0;
                            oerr_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            delok_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            disp_reg       <= '0;
            err_reg        <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            found_reg      <= found_next;
            delok_reg      <= delok_next;
            hold_valid_reg <= hold_valid_next;
            disp_reg       <= disp_next;
            err_reg        <= err_next;
            ov_reg         <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        task_reg      <= task_next;
        fdel_reg      <= fdel_next;
        per_reg       <= per_next;
        idx_reg       <= idx_next;
        rslot_reg     <= rslot_next;
        hold_slot_reg <= hold_slot_next;
        hold_tid_reg  <= hold_tid_next;
        oslot_reg     <= oslot_next;
        otid_reg      <= otid_next;
        ostat_reg     <= ostat_next;
        oerr_reg      <= oerr_next;
        olast_reg     <= olast_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = ov_reg;
    assign slot         = oslot_reg;
    assign run_task_id  = otid_reg;
    assign status       = ostat_reg;
    assign sticky_error = oerr_reg;
    assign last         = olast_reg;

endmodule

`default_nettype wire

// File: src/tts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tts_checker: port-level checks for the task scheduler
// Watches the handshakes and result codes seen on the top-level ports.
// ----------------------------------------------------------------------------
module tts_checker #(
    parameter int SLOTS = 8
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [3:0] slot,
    input wire logic [1:0] status,
    input wire logic       sticky_error,
    input wire logic       last
);
    import tts_pkg::*;

    // The scheduler works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is still in work");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(slot) && $stable(status))
        else $error("stalled result changed");

    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> slot == 4'(SLOTS) && sticky_error && last)
        else $error("table full result malformed");

    a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> sticky_error && last)
        else $error("empty delete without sticky error");

endmodule

bind time_triggered_task_scheduler tts_checker #(.SLOTS(SLOTS)) u_tts_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .slot(slot), .status(status),
    .sticky_error(sticky_error), .last(last)
);

`default_nettype wire
